// ===== rtl/iabt_pkg.sv =====
package iabt_pkg;

    localparam int COLUMN_BITS = 16;
    localparam int LINE_BITS   = 32;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;
    localparam int INDENT_W = 16;
    localparam int POS_W    = 16;
    localparam int LINE_W   = 32;

    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'd95;

    typedef logic [COLUMN_BITS-1:0] col_t;
    typedef logic [LINE_BITS-1:0]   line_t;

    localparam col_t  COL_MAX  = '1;
    localparam line_t LINE_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR        = 2'd0,
        KIND_TOKEN_END   = 2'd1,
        KIND_END_OF_LINE = 2'd2
    } kind_t;

    typedef struct packed {
        line_t line_index;
        col_t  column;
        col_t  line_indent;
        logic  counting_indent;
        logic  token_open;
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        col_t              indent;
        col_t              pos;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        line_t                     line;
        entry_t [MAX_RES-1:0]      ent;
    } bundle_t;

    localparam state_t RESET_STATE = '{
        line_index:      '0,
        column:          '0,
        line_indent:     '0,
        counting_indent: 1'b1,
        token_open:      1'b0
    };

    function automatic col_t col_inc(input col_t v);
        return (v == COL_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        if (c == CHAR_UNDERSCORE) begin
            return 1'b0;
        end
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic state_t line_start(input line_t line);
        state_t s;
        s = RESET_STATE;
        s.line_index = (line == LINE_MAX) ? line : line + 1'b1;
        return s;
    endfunction

    function automatic entry_t mk_entry(input kind_t kind, input logic [CHAR_W-1:0] ch,
                                        input col_t indent, input col_t pos);
        entry_t e;
        e.kind   = kind;
        e.ch     = ch;
        e.indent = indent;
        e.pos    = pos;
        return e;
    endfunction

endpackage

// ===== rtl/iabt_step.sv =====
module iabt_step (
    input  iabt_pkg::state_t              state_cur,
    input  logic [iabt_pkg::CHAR_W-1:0]   character,
    input  logic                          end_of_source,
    output iabt_pkg::state_t              state_next,
    output iabt_pkg::bundle_t             bundle
);
    import iabt_pkg::*;

    always_comb begin
        logic [CNT_W-1:0] n;
        state_t           st;
        col_t             col1;
        n      = '0;
        st     = state_cur;
        col1   = col_inc(state_cur.column);
        bundle = '0;
        bundle.line = state_cur.line_index;

        if (character == CHAR_NEWLINE) begin
            if (state_cur.token_open) begin
                bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_TOKEN_END, '0,
                                                    state_cur.line_indent, state_cur.column);
                n = n + 1'b1;
            end
            bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_END_OF_LINE, '0, '0, state_cur.column);
            n  = n + 1'b1;
            st = line_start(state_cur.line_index);
        end else begin
            if (is_ws(character)) begin
                if (state_cur.token_open) begin
                    bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_TOKEN_END, '0,
                                                        state_cur.line_indent, state_cur.column);
                    n = n + 1'b1;
                end
                st.token_open = 1'b0;
                if (state_cur.counting_indent && character == CHAR_SPACE) begin
                    st.line_indent = col_inc(state_cur.line_indent);
                end else begin
                    st.counting_indent = 1'b0;
                end
            end else if (is_punct(character)) begin
                if (state_cur.token_open) begin
                    bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_TOKEN_END, '0,
                                                        state_cur.line_indent, state_cur.column);
                    n = n + 1'b1;
                end
                bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_CHAR, character,
                                                    state_cur.line_indent, col1);
                n = n + 1'b1;
                bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_TOKEN_END, '0,
                                                    state_cur.line_indent, col1);
                n = n + 1'b1;
                st.token_open      = 1'b0;
                st.counting_indent = 1'b0;
            end else begin
                bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_CHAR, character,
                                                    state_cur.line_indent, col1);
                n = n + 1'b1;
                st.token_open      = 1'b1;
                st.counting_indent = 1'b0;
            end
            st.column = col1;

            // A final byte that is not a newline closes the line as a newline would.
            if (end_of_source) begin
                if (st.token_open) begin
                    bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_TOKEN_END, '0,
                                                        st.line_indent, st.column);
                    n = n + 1'b1;
                end
                bundle.ent[n[IDX_W-1:0]] = mk_entry(KIND_END_OF_LINE, '0, '0, st.column);
                n  = n + 1'b1;
                st = line_start(state_cur.line_index);
            end
        end

        bundle.count = n;
        state_next   = st;
    end

endmodule

// ===== rtl/iabt_emitter.sv =====
module iabt_emitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  iabt_pkg::bundle_t               bundle,
    output logic                            bundle_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iabt_pkg::KIND_W-1:0]     m_kind,
    output logic [iabt_pkg::CHAR_W-1:0]     m_character_res,
    output logic [iabt_pkg::INDENT_W-1:0]   m_indent,
    output logic [iabt_pkg::LINE_W-1:0]     m_line_index,
    output logic [iabt_pkg::POS_W-1:0]      m_end_position,
    output logic                            m_last
);
    import iabt_pkg::*;

    bundle_t          bun_reg;
    logic             bun_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             at_last;
    entry_t           cur_ent;

    assign at_last      = (CNT_W'(idx_reg) + 1'b1) == bun_reg.count;
    assign bundle_ready = !bun_valid_reg || (m_ready && at_last);
    assign cur_ent      = bun_reg.ent[idx_reg];

    assign m_valid         = bun_valid_reg;
    assign m_kind          = cur_ent.kind;
    assign m_character_res = cur_ent.ch;
    assign m_indent        = INDENT_W'(cur_ent.indent);
    assign m_end_position  = POS_W'(cur_ent.pos);
    assign m_line_index    = LINE_W'(bun_reg.line);
    assign m_last          = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bun_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            bun_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (bun_valid_reg && m_ready) begin
            if (at_last) begin
                bun_valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bun_reg <= bundle;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bun_valid_reg |-> (bun_reg.count != '0 && bun_reg.count <= CNT_W'(MAX_RES)))
        else $error("held request bundle has an impossible result count");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bun_valid_reg |-> (CNT_W'(idx_reg) < bun_reg.count))
        else $error("result index ran past the end of the request bundle");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> bundle_ready)
        else $error("request bundle loaded over one still being sent");

    a_drain_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last && !load) |=> !m_valid)
        else $error("output still valid after the last result of a request");
`endif

endmodule

// ===== rtl/indent_aware_byte_tokenizer_core.sv =====
// Byte tokenizer with line indent tracking.
// Input channel (s_valid/s_ready): one source byte per request in s_character,
// with s_end_of_source set on the final byte of the text.
// Output channel (m_valid/m_ready): one result per request, kind 0 for a token
// character, 1 for a token end and 2 for an end of line, with the line's indent
// (zero on an end of line), the line number and the end column. m_last marks
// the final result of a byte. A byte produces zero to four results. An accepted
// byte is held in an input register, then classified combinationally into a
// bundle loaded into the result register, which offers its results. Throughput
// is one byte per cycle while each byte yields at most one result and m_ready
// stays high; a byte with k results holds the output until all k are taken, and
// the next byte is classified in the cycle its predecessor's last result is taken.
// A synchronous active-low reset on aresetn empties both registers and returns
// to line zero, column zero, at the start of a line with no token open.
// When the receiver holds m_ready low, the current result stays on the outputs,
// one more byte waits in the input register and s_ready then falls.
module indent_aware_byte_tokenizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [iabt_pkg::CHAR_W-1:0]     s_character,
    input  logic                            s_end_of_source,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iabt_pkg::KIND_W-1:0]     m_kind,
    output logic [iabt_pkg::CHAR_W-1:0]     m_character_res,
    output logic [iabt_pkg::INDENT_W-1:0]   m_indent,
    output logic [iabt_pkg::LINE_W-1:0]     m_line_index,
    output logic [iabt_pkg::POS_W-1:0]      m_end_position,
    output logic                            m_last
);
    import iabt_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_fin_reg;
    state_t            state_reg;
    state_t            state_next;
    bundle_t           bundle;
    logic              bundle_ready;
    logic              advance;
    logic              load;

    assign advance = in_valid_reg && bundle_ready;
    assign load    = advance && (bundle.count != '0);
    assign s_ready = !in_valid_reg || bundle_ready;

    iabt_step u_step (
        .state_cur     (state_reg),
        .character     (in_char_reg),
        .end_of_source (in_fin_reg),
        .state_next    (state_next),
        .bundle        (bundle)
    );

    iabt_emitter u_emitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .bundle          (bundle),
        .bundle_ready    (bundle_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_character_res (m_character_res),
        .m_indent        (m_indent),
        .m_line_index    (m_line_index),
        .m_end_position  (m_end_position),
        .m_last          (m_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= RESET_STATE;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
            in_fin_reg  <= s_end_of_source;
        end
    end

`ifndef SYNTHESIS
    a_open_token_ends_indent: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.token_open |-> !state_reg.counting_indent)
        else $error("token open while still counting leading spaces");
`endif

endmodule
